@@ rtl/trst_pkg.sv @@
// ----------------------------------------------------------------------------
// trst_pkg: shared types and constants for the touch ring sector tracker
// Word layouts, controller commands, state codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package trst_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int ACC_BITS   = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_BITS  = 4;
   localparam int TOTAL_BITS = 7;
   localparam int MAP_BITS   = 64;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ARC_START    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ARC_END      = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SENSOR_TOTAL = 2'd2;

   localparam logic MODE_CONTACT = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] contact_dx;
      logic [15:0] contact_dy;
   } req_word_type;

   typedef struct packed {
      logic [63:0] hit_map;
      logic [63:0] new_map;
      logic [63:0] released_map;
      logic        changed;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_TEST,
      ST_DIVIDE,
      ST_MARK,
      ST_EMIT
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word, prepare CORDIC
      logic cordic_step;
      logic test;       // round angle, arc test, prepare divide
      logic div_step;
      logic mark;       // set sector bit
      logic emit;       // load output word, roll maps
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_tick;
      logic last_step;  // final CORDIC / divide iteration
      logic in_arc;     // point falls in a live arc
   } dp_status_type;

   function automatic logic [ACC_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] i);
      logic [ACC_BITS-1:0] r;
      unique case (i)
         4'd0:  r = 32'h20000000;
         4'd1:  r = 32'h12E4051E;
         4'd2:  r = 32'h09FB385B;
         4'd3:  r = 32'h051111D4;
         4'd4:  r = 32'h028B0D43;
         4'd5:  r = 32'h0145D7E1;
         4'd6:  r = 32'h00A2F61E;
         4'd7:  r = 32'h00517C55;
         4'd8:  r = 32'h0028BE53;
         4'd9:  r = 32'h00145F2F;
         4'd10: r = 32'h000A2F98;
         4'd11: r = 32'h000517CC;
         4'd12: r = 32'h00028BE6;
         4'd13: r = 32'h000145F3;
         4'd14: r = 32'h0000A2F9;
         4'd15: r = 32'h0000517D;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/trst_ctrl.sv @@
// ----------------------------------------------------------------------------
// trst_ctrl: sequencing controller
// Contact: CORDIC, arc test, sector divide, map update; tick: maps word out.
// ----------------------------------------------------------------------------
module trst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_busy,
   input  trst_pkg::dp_status_type status,
   output trst_pkg::dp_cmd_type    cmd
);

   trst_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         trst_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = trst_pkg::ST_ANGLE;
            end
         end
         trst_pkg::ST_ANGLE: begin
            if (status.is_tick) begin
               if (!rsp_busy) state_in = trst_pkg::ST_EMIT;
            end else begin
               cmd.cordic_step = 1'b1;
               if (status.last_step) state_in = trst_pkg::ST_TEST;
            end
         end
         trst_pkg::ST_TEST: begin
            cmd.test = 1'b1;
            state_in = trst_pkg::ST_DIVIDE;
         end
         trst_pkg::ST_DIVIDE: begin
            if (!status.in_arc) begin
               state_in = trst_pkg::ST_IDLE;
            end else begin
               cmd.div_step = 1'b1;
               if (status.last_step) state_in = trst_pkg::ST_MARK;
            end
         end
         trst_pkg::ST_MARK: begin
            cmd.mark = 1'b1;
            state_in = trst_pkg::ST_IDLE;
         end
         trst_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = trst_pkg::ST_IDLE;
         end
         default: state_in = trst_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ rtl/trst_datapath.sv @@
// ----------------------------------------------------------------------------
// trst_datapath: angle, arc and sector datapath
// Iterative CORDIC vectoring, restoring sector divider and the hit maps.
// ----------------------------------------------------------------------------
module trst_datapath #(
   parameter int MAX_SENSORS = 64,
   parameter int COORD_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  trst_pkg::req_word_type  req_word,
   input  trst_pkg::dp_cmd_type    cmd,
   output trst_pkg::dp_status_type status,
   input  logic                    cfg_clear,
   input  logic [15:0]             arc_start,
   input  logic [15:0]             arc_end,
   input  logic [6:0]              sensor_total,
   output trst_pkg::rsp_word_type  rsp_word
);

   // coordinates scaled by 2^14 plus growth of the CORDIC gain
   localparam int XW = COORD_BITS + 14 + 3;
   localparam int PW = 16 + 7;              // offset * n
   localparam int IW = $clog2(MAX_SENSORS);
   localparam int IB = (IW < 1) ? 1 : IW;

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]          acc_ff, acc_in;
   logic [4:0]           step_ff, step_in;
   logic                 tick_ff, in_arc_ff;
   logic                 origin_ff;
   logic [15:0]          span_ff;
   logic [6:0]           n_ff;
   logic [PW-1:0]        num_ff;      // dividend, shifted out msb first
   logic [15:0]          rem_ff;
   logic [6:0]           quo_ff;
   logic [63:0]          cur_ff, prev_ff;

   logic signed [COORD_BITS-1:0] dx, dy;
   logic signed [XW-1:0] sx, sy, xs, ys;
   logic [15:0]  ang, offs, span;
   logic [6:0]   n_eff;
   logic         hit;
   logic [16:0]  rem_sh;
   logic [6:0]   idx;

   assign dx = req_word.contact_dx[COORD_BITS-1:0];
   assign dy = req_word.contact_dy[COORD_BITS-1:0];
   assign sx = XW'(dx) <<< 14;
   assign sy = XW'(dy) <<< 14;
   assign xs = x_ff >>> step_ff[3:0];
   assign ys = y_ff >>> step_ff[3:0];

   // origin point has angle 0
   assign ang  = origin_ff ? 16'd0 : 16'((acc_ff + 32'h8000) >> 16);
   assign offs = ang - arc_start;
   assign span = arc_end - arc_start;
   assign n_eff = (sensor_total > 7'(MAX_SENSORS)) ? 7'(MAX_SENSORS) : sensor_total;
   always_comb begin
      if (arc_start < arc_end) hit = (ang >= arc_start) && (ang <= arc_end);
      else                     hit = (ang >= arc_start) || (ang <= arc_end);
      hit = hit && (arc_start != arc_end) && (n_eff != 7'd0);
   end

   assign rem_sh = {rem_ff, num_ff[PW-1]};
   assign idx = (quo_ff >= n_ff) ? n_ff - 7'd1 : quo_ff;

   always_comb begin
      x_in = x_ff; y_in = y_ff; acc_in = acc_ff; step_in = step_ff;
      if (cmd.load) begin
         step_in = '0;
         if (sx < 0) begin
            x_in = -sx; y_in = -sy; acc_in = 32'h80000000;
         end else begin
            x_in = sx; y_in = sy; acc_in = '0;
         end
      end else if (cmd.cordic_step) begin
         step_in = step_ff + 5'd1;
         if (y_ff >= 0) begin
            x_in = x_ff + ys; y_in = y_ff - xs;
            acc_in = acc_ff + trst_pkg::atan_turn(step_ff[3:0]);
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs;
            acc_in = acc_ff - trst_pkg::atan_turn(step_ff[3:0]);
         end
      end else if (cmd.test) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in; step_ff <= step_in;
      if (cmd.load) begin
         tick_ff   <= req_word.mode == trst_pkg::MODE_TICK;
         origin_ff <= (dx == '0) && (dy == '0);
      end
      if (cmd.test) begin
         in_arc_ff <= hit;
         span_ff   <= span;
         n_ff      <= n_eff;
         num_ff    <= PW'(offs) * PW'(n_eff);
         rem_ff    <= '0;
         quo_ff    <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         if (rem_sh >= {1'b0, span_ff}) begin
            rem_ff <= 16'(rem_sh - {1'b0, span_ff});
            quo_ff <= {quo_ff[5:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[15:0];
            quo_ff <= {quo_ff[5:0], 1'b0};
         end
      end
      if (cmd.emit) begin
         rsp_word.hit_map      <= cur_ff;
         rsp_word.new_map      <= cur_ff & ~prev_ff;
         rsp_word.released_map <= prev_ff & ~cur_ff;
         rsp_word.changed      <= (cur_ff ^ prev_ff) != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         cur_ff  <= '0;
         prev_ff <= '0;
      end else if (cmd.mark) begin
         cur_ff[idx[IB-1:0]] <= 1'b1;
      end else if (cmd.emit) begin
         prev_ff <= cur_ff;
         cur_ff  <= '0;
      end
   end

   assign status.is_tick   = tick_ff;
   assign status.in_arc    = in_arc_ff;
   assign status.last_step = cmd.cordic_step ? (step_ff == 5'd15) : (step_ff == 5'(PW-1));

endmodule

@@ rtl/touch_ring_sector_tracker.sv @@
// ----------------------------------------------------------------------------
// touch_ring_sector_tracker: sector hit tracker for a ring of touch sensors
// Angle by iterative CORDIC, arc check, sector index by serial divide.
// ----------------------------------------------------------------------------
//  channel | ports                   | role
//  req     | req_valid/ready/word    | contact point or tick marker in
//  rsp     | rsp_valid/ready/word    | maps word out, one per tick marker
//  csr     | csr_write/index/data    | arc_start, arc_end, sensor_total
//
// Contact word: accept, 16 CORDIC steps, test, 23 divide steps, sector mark
// (a miss returns to idle from the divide state). The iterative CORDIC stage
// gives the angle, the one-bit-per-cycle restoring divider the sector index.
// Tick word: it waits in ANGLE while the previous response is unread.
// Reset is synchronous; registers return to 0 / 65535 / 32, maps clear.
module touch_ring_sector_tracker #(
   parameter int MAX_SENSORS = 64,
   parameter int COORD_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  trst_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output trst_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data
);

   logic [15:0] arc_start_ff, arc_end_ff;
   logic [6:0]  total_ff;
   logic        rsp_valid_ff;
   logic        cfg_clear;
   trst_pkg::dp_cmd_type    cmd;
   trst_pkg::dp_status_type status;

   // listed registers clear the maps on write
   assign cfg_clear = csr_write && (csr_index == trst_pkg::CSR_ARC_START ||
                      csr_index == trst_pkg::CSR_ARC_END ||
                      csr_index == trst_pkg::CSR_SENSOR_TOTAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         arc_start_ff <= '0;
         arc_end_ff   <= 16'hFFFF;
         total_ff     <= 7'd32;
      end else if (csr_write) begin
         unique case (csr_index)
            trst_pkg::CSR_ARC_START:    arc_start_ff <= csr_data;
            trst_pkg::CSR_ARC_END:      arc_end_ff   <= csr_data;
            trst_pkg::CSR_SENSOR_TOTAL: total_ff     <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // output register: set on emit, cleared when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   trst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_busy  (rsp_valid_ff && !rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   trst_datapath #(
      .MAX_SENSORS (MAX_SENSORS),
      .COORD_BITS  (COORD_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_word     (req_word),
      .cmd          (cmd),
      .status       (status),
      .cfg_clear    (cfg_clear),
      .arc_start    (arc_start_ff),
      .arc_end      (arc_end_ff),
      .sensor_total (total_ff),
      .rsp_word     (rsp_word)
   );

   // emit never overwrites an unread response
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response overrun");

   // at most one datapath command per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("conflicting datapath commands");

endmodule

@@ dv/trst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trst_checker: scoreboard for the touch ring sector tracker
// Watches the req, rsp and csr ports, predicts the maps for each tick word
// and compares every response word field by field.
// ----------------------------------------------------------------------------
module trst_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  trst_pkg::req_word_type           req_word,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  trst_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_write,
   input  logic [1:0]                       csr_index,
   input  logic [15:0]                      csr_data,
   output int                               fail_count,
   output int                               pending
);

   localparam int DUE_DEPTH = 16;

   localparam logic [31:0] ATAN_TURNS [16] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D};

   logic [15:0] arc_lo, arc_hi;
   logic [6:0]  sectors;
   logic [63:0] tick_hits, last_hits;
   trst_pkg::rsp_word_type maps_due [DUE_DEPTH];
   int due_wr, due_rd;

   initial fail_count = 0;
   assign pending = due_wr - due_rd;

   // binary angle of a point, 65536 per turn
   function automatic logic [15:0] turn_angle(logic signed [15:0] dx, logic signed [15:0] dy);
      longint x, y, xs, ys;
      logic [31:0] acc;
      x = longint'(dx) * 16384;
      y = longint'(dy) * 16384;
      acc = '0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = 32'h80000000;
      end
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            acc = acc + ATAN_TURNS[i];
         end else begin
            x = x - ys;
            y = y + xs;
            acc = acc - ATAN_TURNS[i];
         end
      end
      acc = acc + 32'h8000;
      return acc[31:16];
   endfunction

   function automatic logic [63:0] sector_bit(logic [15:0] a);
      logic [31:0] n, offset, span, idx;
      logic hit;
      n = (sectors > 7'd64) ? 32'd64 : 32'(sectors);
      if (n == 0 || arc_lo == arc_hi) return '0;
      if (arc_lo < arc_hi) hit = (a >= arc_lo) && (a <= arc_hi);
      else                 hit = (a >= arc_lo) || (a <= arc_hi);
      if (!hit) return '0;
      offset = 32'(16'(a - arc_lo));
      span   = 32'(16'(arc_hi - arc_lo));
      idx    = (offset * n) / span;
      if (idx >= n) idx = n - 1;   // point right at the arc end
      return 64'd1 << idx[5:0];
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      trst_pkg::rsp_word_type want;
      logic [63:0] fresh, gone;
      logic listed;
      if (reset) begin
         arc_lo = 16'd0;
         arc_hi = 16'hFFFF;
         sectors = 7'd32;
         tick_hits = '0;
         last_hits = '0;
         due_wr = 0;
         due_rd = 0;
      end else begin
         if (csr_write) begin
            listed = 1'b1;
            case (csr_index)
               trst_pkg::CSR_ARC_START:    arc_lo = csr_data;
               trst_pkg::CSR_ARC_END:      arc_hi = csr_data;
               trst_pkg::CSR_SENSOR_TOTAL: sectors = csr_data[6:0];
               default:                    listed = 1'b0;
            endcase
            if (listed) begin
               tick_hits = '0;
               last_hits = '0;
            end
         end
         if (req_valid && req_ready) begin
            if (req_word.mode == trst_pkg::MODE_CONTACT) begin
               tick_hits |= sector_bit(turn_angle(req_word.contact_dx, req_word.contact_dy));
            end else begin
               fresh = tick_hits & ~last_hits;
               gone  = last_hits & ~tick_hits;
               want  = '{tick_hits, fresh, gone, (fresh | gone) != 0};
               if (due_wr - due_rd >= DUE_DEPTH) begin
                  report("expected words overflow", 64'(due_wr - due_rd), '0);
               end else begin
                  maps_due[due_wr % DUE_DEPTH] = want;
                  due_wr++;
               end
               last_hits = tick_hits;
               tick_hits = '0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (due_wr == due_rd) begin
               report("unexpected word", rsp_word.hit_map, '0);
            end else begin
               want = maps_due[due_rd % DUE_DEPTH];
               due_rd++;
               if (rsp_word.hit_map !== want.hit_map)
                  report("hit_map", rsp_word.hit_map, want.hit_map);
               if (rsp_word.new_map !== want.new_map)
                  report("new_map", rsp_word.new_map, want.new_map);
               if (rsp_word.released_map !== want.released_map)
                  report("released_map", rsp_word.released_map, want.released_map);
               if (rsp_word.changed !== want.changed)
                  report("changed", 64'(rsp_word.changed), 64'(want.changed));
            end
         end
      end
   end

endmodule

@@ dv/tb_touch_ring_sector_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_ring_sector_tracker: stimulus and verdict for the sector tracker
// Directed corner points and arcs, then random phases of contact and tick
// words under several arc settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_touch_ring_sector_tracker;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE = 60;        // covers a contact word in flight

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   trst_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   trst_pkg::rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   int fail_count, pending;
   bit quiet = 0;        // no idling on either side
   bit hold_rsp = 0;     // ask receiver for one long hold-off

   always #5 clock = ~clock;

   touch_ring_sector_tracker dut (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .rsp_valid, .rsp_ready, .rsp_word, .csr_write, .csr_index, .csr_data);

   trst_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_word,
      .rsp_valid, .rsp_ready, .rsp_word, .csr_write, .csr_index, .csr_data,
      .fail_count, .pending);

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // called at a rising edge; returns at the edge that accepts the word
   task automatic send_word(logic m, logic [15:0] dx, logic [15:0] dy);
      bit rd;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{m, dx, dy};
      do begin
         @(negedge clock);
         rd = req_ready;
         @(posedge clock);
      end while (!rd);
   endtask

   task automatic csr_put(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // sender pause: wait out every pending maps word plus a contact's latency
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_arc(logic [15:0] lo, logic [15:0] hi, logic [15:0] n);
      csr_put(trst_pkg::CSR_ARC_START, lo);
      csr_put(trst_pkg::CSR_ARC_END, hi);
      csr_put(trst_pkg::CSR_SENSOR_TOTAL, n);
   endtask

   task automatic contact(logic [15:0] dx, logic [15:0] dy);
      send_word(trst_pkg::MODE_CONTACT, dx, dy);
   endtask

   task automatic tick();
      send_word(trst_pkg::MODE_TICK, 16'($urandom), 16'($urandom));
   endtask

   // random contact: mostly full range, some small offsets near the centre
   task automatic random_contact();
      if ($urandom_range(0, 3) == 0)
         contact(16'($signed($urandom_range(0, 40)) - 20),
                 16'($signed($urandom_range(0, 40)) - 20));
      else
         contact(16'($urandom), 16'($urandom));
   endtask

   task automatic random_phase(int count);
      logic [15:0] n;
      case ($urandom_range(0, 5))
         0: n = 16'd1;
         1: n = 16'd64;
         2: n = 16'($urandom_range(65, 127));
         default: n = 16'($urandom_range(1, 64)) | (16'($urandom) & 16'hFF80);
      endcase
      set_arc(16'($urandom), 16'($urandom), n);
      if ($urandom_range(0, 2) == 0) csr_put(CSR_UNUSED, 16'($urandom));
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 5) == 0) tick();
         else random_contact();
      end
      tick();
      drain();
   endtask

   initial begin
      logic [15:0] a;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: origin and coordinate extremes at reset settings
      contact(16'd0, 16'd0);
      contact(16'h7FFF, 16'd0);
      contact(16'h8000, 16'd0);
      contact(16'd0, 16'h7FFF);
      contact(16'd0, 16'h8000);
      contact(16'h8000, 16'h8000);
      contact(16'h7FFF, 16'h7FFF);
      tick();
      tick();                        // nothing touched: all released
      drain();

      // point exactly at the arc end clamps to the last sector
      a = chk.turn_angle(16'sd100, 16'sd50);
      set_arc(16'd0, a, 16'd8);
      contact(16'd100, 16'd50);
      tick();
      drain();

      // arc wrapping through zero
      set_arc(16'd60000, 16'd5000, 16'd16);
      contact(16'd1000, 16'd0);
      contact(16'd1000, 16'hFFD0);
      contact(16'hFC00, 16'd0);      // outside
      tick();
      drain();

      // empty arc, no sectors, too many sectors, unknown register
      set_arc(16'd1000, 16'd1000, 16'd8);
      contact(16'd100, 16'd100);
      tick();
      drain();
      set_arc(16'd0, 16'hFFFF, 16'd0);
      contact(16'd100, 16'd100);
      tick();
      drain();
      set_arc(16'd0, 16'hFFFF, 16'hFFFF);
      csr_put(CSR_UNUSED, 16'hFFFF);
      contact(16'hFFFF, 16'hFFFF);
      contact(16'd1, 16'd0);
      tick();
      drain();

      // random phases; the third one runs under a long receiver hold-off
      for (int p = 0; p < 10; p++) begin
         if (p == 2) hold_rsp = 1;
         if (p >= 8) quiet = 1;
         if (p == 2) begin
            set_arc(16'($urandom), 16'($urandom), 16'($urandom_range(1, 64)));
            for (int i = 0; i < 80; i++) begin
               if (i % 3 == 0) tick();     // ticks back up behind the stall
               else random_contact();
            end
            drain();
         end else begin
            random_phase(80);
         end
      end

      if (fail_count == 0) begin
         $display("touch_ring_sector_tracker test passed");
      end else begin
         $display("touch_ring_sector_tracker test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("touch_ring_sector_tracker test failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/trst_pkg.sv
rtl/trst_ctrl.sv
rtl/trst_datapath.sv
rtl/touch_ring_sector_tracker.sv
dv/trst_checker.sv
dv/tb_touch_ring_sector_tracker.sv
